@@ src/tlic_pkg.sv @@
// Shared types, constants and summary-map functions of the two-level interrupt controller.
// Used by tlic_ctrl, tlic_dp and two_level_interrupt_controller_top; depends on nothing.
package tlic_pkg;

    localparam int NUM_GROUPS = 11;
    localparam int REG_WIDTH  = 32;
    localparam int GRP_IDX_W  = $clog2(NUM_GROUPS);
    localparam int MAP_LEN    = 13;

    localparam int KIND_W  = 4;
    localparam int GROUP_W = 4;
    localparam int BIT_W   = 5;
    localparam int DATA_W  = 32;

    // Bit 31 of the master register is the global enable.
    localparam int MASTER_EN_BIT = 31;

    localparam logic [REG_WIDTH-1:0] LO_HALF = REG_WIDTH'(32'h0000_ffff);
    localparam logic [REG_WIDTH-1:0] HI_HALF = REG_WIDTH'(32'hffff_0000);

    typedef enum logic [KIND_W-1:0] {
        KIND_EVENT     = 4'd0,
        KIND_WR_MASK   = 4'd1,
        KIND_WR_ENABLE = 4'd2,
        KIND_WR_ID_CLR = 4'd3,
        KIND_WR_MASTER = 4'd4,
        KIND_RD_MASK   = 4'd5,
        KIND_RD_ENABLE = 4'd6,
        KIND_RD_ID     = 4'd7,
        KIND_RD_MASTER = 4'd8
    } kind_t;

    // Which half of a group's live bits, or both, drives a summary bit.
    typedef enum logic [1:0] {
        SEL_LO,
        SEL_HI,
        SEL_ALL
    } map_sel_t;

    localparam logic [GROUP_W-1:0] MAP_GROUP [MAP_LEN] = '{
        4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10
    };
    localparam logic [4:0] MAP_BIT [MAP_LEN] = '{
        5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd6, 5'd16, 5'd17, 5'd18, 5'd20, 5'd22, 5'd23, 5'd30
    };
    localparam map_sel_t MAP_SEL [MAP_LEN] = '{
        SEL_LO, SEL_HI, SEL_LO, SEL_HI, SEL_LO, SEL_LO,
        SEL_ALL, SEL_ALL, SEL_ALL, SEL_ALL, SEL_ALL, SEL_ALL, SEL_ALL
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic exec;
    } ctrl_cmd_t;

    function automatic logic map_hit(map_sel_t sel, logic lo, logic hi);
        logic r;
        case (sel)
            SEL_LO:  r = lo;
            SEL_HI:  r = hi;
            default: r = lo | hi;
        endcase
        return r;
    endfunction

    // Sets or clears every summary bit mapped from group g.
    function automatic logic [31:0] summary_apply(logic [31:0] m, logic [GROUP_W-1:0] g,
                                                  logic lo, logic hi);
        logic [31:0] r;
        r = m;
        for (int e = 0; e < MAP_LEN; e++) begin
            if (MAP_GROUP[e] == g) begin
                r[MAP_BIT[e]] = map_hit(MAP_SEL[e], lo, hi);
            end
        end
        return r;
    endfunction

    // Refreshes the summary bits of every group whose live bits are nonzero.
    function automatic logic [31:0] pending_apply(logic [31:0] m,
                                                  logic [NUM_GROUPS-1:0] lo_vec,
                                                  logic [NUM_GROUPS-1:0] hi_vec);
        logic [31:0] r;
        logic        lo;
        logic        hi;
        r = m;
        for (int e = 0; e < MAP_LEN; e++) begin
            lo = lo_vec[MAP_GROUP[e]];
            hi = hi_vec[MAP_GROUP[e]];
            if (lo | hi) begin
                r[MAP_BIT[e]] = map_hit(MAP_SEL[e], lo, hi);
            end
        end
        return r;
    endfunction

endpackage

@@ src/two_level_interrupt_controller_top.sv @@
// Two-level interrupt controller: each word is captured in the idle state, then executed against
// the group registers in the execute state once the result register is free; no new word is taken
// until it has executed. The result register is loaded when the word executes, and a new word
// can be captured while that result waits on the output side.
// Reset (aresetn, synchronous, active low) clears all group registers, the master register
// and the handshake state at once; no clearing pass is needed.
module two_level_interrupt_controller_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tlic_pkg::KIND_W-1:0]       s_kind,
    input  logic [tlic_pkg::GROUP_W-1:0]      s_group,
    input  logic [tlic_pkg::BIT_W-1:0]        s_bit_index,
    input  logic [tlic_pkg::DATA_W-1:0]       s_write_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_msi_inject,
    output logic [tlic_pkg::DATA_W-1:0]       m_read_data,
    output logic                              m_error
);
    import tlic_pkg::*;

    // The controller only issues commands; all group, master and result register state lives in the datapath.
    ctrl_cmd_t cmd;

    // The controller takes a word when idle, then executes it as soon as the result
    // register is empty or being drained in the same cycle.
    tlic_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // The datapath applies events and register writes, serves reads, keeps cached per-group flags
    // of which halves of (identity AND enable) are nonzero, and uses those flags to refresh the
    // master summary bits and decide on an MSI in the execute cycle.
    tlic_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_kind       (s_kind),
        .s_group      (s_group),
        .s_bit_index  (s_bit_index),
        .s_write_data (s_write_data),
        .m_msi_inject (m_msi_inject),
        .m_read_data  (m_read_data),
        .m_error      (m_error)
    );

endmodule

@@ src/tlic_ctrl.sv @@
// Controller of the interrupt controller: sequences capture and execution of one word.
// Depends on tlic_pkg for the command struct.
module tlic_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output tlic_pkg::ctrl_cmd_t cmd
);
    import tlic_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        cmd.load_item = 1'b0;
        cmd.exec      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // The result register must be free before the item executes.
                if (out_free) begin
                    cmd.exec     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ src/tlic_dp.sv @@
// Datapath of the interrupt controller: group registers, master register and result register.
// Depends on tlic_pkg for sizes, kind codes and the summary map functions.
module tlic_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tlic_pkg::ctrl_cmd_t               cmd,
    input  logic [tlic_pkg::KIND_W-1:0]       s_kind,
    input  logic [tlic_pkg::GROUP_W-1:0]      s_group,
    input  logic [tlic_pkg::BIT_W-1:0]        s_bit_index,
    input  logic [tlic_pkg::DATA_W-1:0]       s_write_data,
    output logic                              m_msi_inject,
    output logic [tlic_pkg::DATA_W-1:0]       m_read_data,
    output logic                              m_error
);
    import tlic_pkg::*;

    // Captured word.
    logic [KIND_W-1:0]  kind_reg;
    logic [GROUP_W-1:0] group_reg;
    logic [BIT_W-1:0]   bit_reg;
    logic [DATA_W-1:0]  wdata_reg;

    // Architectural state.
    logic [REG_WIDTH-1:0]  mask_reg [NUM_GROUPS];
    logic [REG_WIDTH-1:0]  id_reg   [NUM_GROUPS];
    logic [REG_WIDTH-1:0]  en_reg   [NUM_GROUPS];
    logic [31:0]           master_reg;
    logic [NUM_GROUPS-1:0] hit_lo_reg;
    logic [NUM_GROUPS-1:0] hit_hi_reg;

    // Result register.
    logic              msi_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic              err_reg;

    logic [GRP_IDX_W-1:0]  gidx;
    logic                  uses_group;
    logic                  group_bad;
    logic [REG_WIDTH-1:0]  cur_mask;
    logic [REG_WIDTH-1:0]  cur_id;
    logic [REG_WIDTH-1:0]  cur_en;
    logic [31:0]           one_hot;
    logic [REG_WIDTH-1:0]  bit_vec;
    logic [REG_WIDTH-1:0]  wdata_n;
    logic [REG_WIDTH-1:0]  mask_next;
    logic [REG_WIDTH-1:0]  id_next;
    logic [REG_WIDTH-1:0]  en_next;
    logic [REG_WIDTH-1:0]  live_next;
    logic                  lo_next;
    logic                  hi_next;
    logic [NUM_GROUPS-1:0] hit_lo_next;
    logic [NUM_GROUPS-1:0] hit_hi_next;
    logic                  grp_wr;
    logic                  do_update;
    logic                  do_pend;
    logic [31:0]           master_a;
    logic [31:0]           master_next;
    logic                  msi_next;
    logic [DATA_W-1:0]     rdata_next;
    logic                  err_next;

    assign gidx      = GRP_IDX_W'(group_reg);
    assign cur_mask  = mask_reg[gidx];
    assign cur_id    = id_reg[gidx];
    assign cur_en    = en_reg[gidx];
    assign one_hot   = 32'd1 << bit_reg;
    assign bit_vec   = one_hot[REG_WIDTH-1:0];
    assign wdata_n   = wdata_reg[REG_WIDTH-1:0];

    assign uses_group = (kind_reg == KIND_EVENT) || (kind_reg == KIND_WR_MASK)
                     || (kind_reg == KIND_WR_ENABLE) || (kind_reg == KIND_WR_ID_CLR)
                     || (kind_reg == KIND_RD_MASK) || (kind_reg == KIND_RD_ENABLE)
                     || (kind_reg == KIND_RD_ID);
    assign group_bad  = uses_group && (int'(group_reg) >= NUM_GROUPS);

    always_comb begin
        mask_next  = cur_mask;
        id_next    = cur_id;
        en_next    = cur_en;
        grp_wr     = 1'b0;
        do_update  = 1'b0;
        do_pend    = 1'b0;
        master_a   = master_reg;
        rdata_next = '0;
        err_next   = 1'b0;
        if (group_bad) begin
            err_next = 1'b1;
        end else begin
            unique case (kind_reg)
                KIND_EVENT: begin
                    if (!(|(cur_mask & bit_vec))) begin
                        id_next = cur_id | bit_vec;
                    end
                    grp_wr  = 1'b1;
                    do_pend = 1'b1;
                end
                KIND_WR_MASK: begin
                    mask_next = wdata_n;
                    grp_wr    = 1'b1;
                    do_pend   = 1'b1;
                end
                KIND_WR_ENABLE: begin
                    en_next   = wdata_n;
                    grp_wr    = 1'b1;
                    do_update = 1'b1;
                    do_pend   = 1'b1;
                end
                KIND_WR_ID_CLR: begin
                    id_next   = cur_id & ~wdata_n;
                    grp_wr    = 1'b1;
                    do_update = 1'b1;
                end
                KIND_WR_MASTER: begin
                    master_a[MASTER_EN_BIT] = wdata_reg[MASTER_EN_BIT];
                    do_pend                 = 1'b1;
                end
                KIND_RD_MASK:   rdata_next = DATA_W'(cur_mask);
                KIND_RD_ENABLE: rdata_next = DATA_W'(cur_en);
                KIND_RD_ID:     rdata_next = DATA_W'(cur_id);
                KIND_RD_MASTER: rdata_next = master_reg;
                default: ;
            endcase
        end
    end

    // Live bits of the addressed group after this word, split into the two map halves.
    assign live_next = id_next & en_next;
    assign lo_next   = |(live_next & LO_HALF);
    assign hi_next   = |(live_next & HI_HALF);

    always_comb begin
        hit_lo_next = hit_lo_reg;
        hit_hi_next = hit_hi_reg;
        if (grp_wr) begin
            hit_lo_next[gidx] = lo_next;
            hit_hi_next[gidx] = hi_next;
        end
    end

    always_comb begin
        master_next = master_a;
        if (do_update) begin
            master_next = summary_apply(master_next, group_reg, lo_next, hi_next);
        end
        msi_next = 1'b0;
        if (do_pend && master_next[MASTER_EN_BIT]) begin
            master_next = pending_apply(master_next, hit_lo_next, hit_hi_next);
            msi_next    = |master_next[MASTER_EN_BIT-1:0];
        end
    end

    // Captured word and result register: payload only.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg  <= s_kind;
            group_reg <= s_group;
            bit_reg   <= s_bit_index;
            wdata_reg <= s_write_data;
        end
        if (cmd.exec) begin
            msi_reg   <= msi_next;
            rdata_reg <= rdata_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                mask_reg[g] <= '0;
                id_reg[g]   <= '0;
                en_reg[g]   <= '0;
            end
            master_reg <= '0;
            hit_lo_reg <= '0;
            hit_hi_reg <= '0;
        end else if (cmd.exec) begin
            if (grp_wr) begin
                mask_reg[gidx] <= mask_next;
                id_reg[gidx]   <= id_next;
                en_reg[gidx]   <= en_next;
            end
            master_reg <= master_next;
            hit_lo_reg <= hit_lo_next;
            hit_hi_reg <= hit_hi_next;
        end
    end

    assign m_msi_inject = msi_reg;
    assign m_read_data  = rdata_reg;
    assign m_error      = err_reg;

endmodule
